### rtl/tgmm_pkg.sv
`timescale 1ns / 1ps
// shared types and widths for the timestamp group median merge
// no dependencies

package tgmm_pkg;

	localparam int SYM_W   = 16;
	localparam int STAMP_W = 27;
	localparam int PRICE_W = 32;
	localparam int MODE_W  = 8;
	localparam int SIZE_W  = 6;
	localparam int IN_DATA_W  = 144;
	localparam int OUT_DATA_W = 152;

	// control broadcast to every cell of the sorted chain
	typedef struct packed {
		logic wr;      // cell may take a new value this cycle
		logic start;   // a new group opens at cell 0
		logic adv_lo;  // lower middle marker moves one cell up
		logic adv_hi;  // upper middle marker moves one cell up
	} ctl_t;

	// what a cell hands to its right-hand neighbor
	typedef struct packed {
		logic [PRICE_W-1:0] bid;
		logic [PRICE_W-1:0] offer;
		logic               bid_gt;
		logic               offer_gt;
		logic               lo;
		logic               hi;
	} link_t;

endpackage

### rtl/tgmm_cell.sv
`timescale 1ns / 1ps
// one cell of the sorted insertion chain: a bid, an offer and the middle markers
// depends on tgmm_pkg

module tgmm_cell import tgmm_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  ctl_t               ctl,
	input  logic               occ,
	input  logic               free,
	input  logic [PRICE_W-1:0] in_bid,
	input  logic [PRICE_W-1:0] in_offer,
	input  link_t              left,
	output link_t              link
);

	logic [PRICE_W-1:0] bid_q;
	logic [PRICE_W-1:0] offer_q;
	logic               lo_q;
	logic               hi_q;
	logic               bid_gt;
	logic               offer_gt;

	// held value lies above the new one, so it moves right
	assign bid_gt   = occ && (bid_q > in_bid);
	assign offer_gt = occ && (offer_q > in_offer);

	always_ff @(posedge clk) begin
		if (ctl.wr) begin
			if (bid_gt || free) begin
				bid_q <= left.bid_gt ? left.bid : in_bid;
			end
			if (offer_gt || free) begin
				offer_q <= left.offer_gt ? left.offer : in_offer;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lo_q <= 1'b0;
			hi_q <= 1'b0;
		end else if (ctl.wr) begin
			if (ctl.start) begin
				lo_q <= free;
				hi_q <= free;
			end else begin
				if (ctl.adv_lo) begin
					lo_q <= left.lo;
				end
				if (ctl.adv_hi) begin
					hi_q <= left.hi;
				end
			end
		end
	end

	assign link.bid      = bid_q;
	assign link.offer    = offer_q;
	assign link.bid_gt   = bid_gt;
	assign link.offer_gt = offer_gt;
	assign link.lo       = lo_q;
	assign link.hi       = hi_q;

endmodule

### rtl/timestamp_group_median_merge.sv
`timescale 1ns / 1ps
// top level: quote grouping by timestamp with median bid and offer per group
// depends on tgmm_pkg and tgmm_cell
//
// Quotes arrive one beat at a time on the s_ side and are gathered into a group
// for as long as their date and time match the group's. A quote with another
// timestamp, or a flush beat (s_tuser high, tdata ignored), closes the group and
// one merged quote leaves on the m_ side: the group's date and time, the symbol
// and mode of its latest kept quote, the medians of its bids and offers (floor mean
// of the two middle values for an even count), its size (saturating at 63) and
// an overflow flag set when quotes beyond MAX_GROUP were dropped. A flush with
// no group pending produces nothing. The block takes one beat per clock cycle:
// prices are kept sorted in a row of MAX_GROUP cells, each comparing its held
// price with the new one and shifting right in the same cycle, while two
// one-hot markers ride the row to point at the middle cells. Any input beat is
// held off while the single output register is full and not being taken; the
// first beat is taken as soon as reset is released.

module timestamp_group_median_merge import tgmm_pkg::*; #(
	parameter int MAX_GROUP = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// symbol_id, quote_date, quote_time, bid_price, offer_price, quote_mode, zero pad
	input  logic [IN_DATA_W-1:0]  s_tdata,
	// flush
	input  logic                  s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// out_symbol, out_date, out_time, median_offer, median_bid, out_mode,
	// group_size, overflow, zero pad
	output logic [OUT_DATA_W-1:0] m_tdata
);

	localparam int CW = $clog2(MAX_GROUP + 1);
	localparam int SW = (CW > SIZE_W) ? CW : SIZE_W;

	// input beat fields
	logic [SYM_W-1:0]   in_sym;
	logic [STAMP_W-1:0] in_date;
	logic [STAMP_W-1:0] in_time;
	logic [PRICE_W-1:0] in_bid;
	logic [PRICE_W-1:0] in_offer;
	logic [MODE_W-1:0]  in_mode;

	assign in_sym   = s_tdata[15:0];
	assign in_date  = s_tdata[42:16];
	assign in_time  = s_tdata[69:43];
	assign in_bid   = s_tdata[101:70];
	assign in_offer = s_tdata[133:102];
	assign in_mode  = s_tdata[141:134];

	// group state
	logic [CW-1:0]      count_q;
	logic [STAMP_W-1:0] date_q;
	logic [STAMP_W-1:0] time_q;
	logic [SYM_W-1:0]   sym_q;
	logic [MODE_W-1:0]  mode_q;
	logic               dropped_q;

	// output register
	logic                  out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;

	logic accept;
	logic empty;
	logic same_stamp;
	logic full;
	logic do_start;
	logic do_insert;
	logic do_drop;
	logic do_emit;
	logic do_flush;
	ctl_t ctl;

	// accept while the output slot is free or draining this cycle
	assign s_tready = !out_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;

	assign empty      = (count_q == '0);
	assign same_stamp = (in_date == date_q) && (in_time == time_q);
	assign full       = (count_q >= CW'(MAX_GROUP));

	always_comb begin
		do_start  = 1'b0;
		do_insert = 1'b0;
		do_drop   = 1'b0;
		do_emit   = 1'b0;
		do_flush  = 1'b0;
		if (accept) begin
			priority if (s_tuser) begin
				do_flush = 1'b1;
				do_emit  = !empty;
			end else if (empty) begin
				do_start = 1'b1;
			end else if (same_stamp) begin
				do_drop   = full;
				do_insert = !full;
			end else begin
				// new timestamp closes the group and opens the next
				do_emit  = 1'b1;
				do_start = 1'b1;
			end
		end
	end

	assign ctl.wr     = do_start || do_insert;
	assign ctl.start  = do_start;
	// lower middle moves when the count goes even to odd, upper when odd to even
	assign ctl.adv_lo = !count_q[0];
	assign ctl.adv_hi = count_q[0];

	// sorted chain of cells
	link_t chain [MAX_GROUP+1];
	logic [CW-1:0] eff_count;

	assign eff_count = do_start ? '0 : count_q;

	assign chain[0] = '0;

	for (genvar i = 0; i < MAX_GROUP; i++) begin : g_cell
		logic occ;
		logic free;
		assign occ  = (CW'(i) < eff_count);
		assign free = (CW'(i) == eff_count);
		tgmm_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.occ      (occ),
			.free     (free),
			.in_bid   (in_bid),
			.in_offer (in_offer),
			.left     (chain[i]),
			.link     (chain[i+1])
		);
	end

	// pick the middle cells through their one-hot markers
	logic [PRICE_W-1:0] bid_lo;
	logic [PRICE_W-1:0] bid_hi;
	logic [PRICE_W-1:0] offer_lo;
	logic [PRICE_W-1:0] offer_hi;

	always_comb begin
		bid_lo   = '0;
		bid_hi   = '0;
		offer_lo = '0;
		offer_hi = '0;
		for (int k = 1; k <= MAX_GROUP; k++) begin
			bid_lo   = bid_lo   | (chain[k].bid   & {PRICE_W{chain[k].lo}});
			bid_hi   = bid_hi   | (chain[k].bid   & {PRICE_W{chain[k].hi}});
			offer_lo = offer_lo | (chain[k].offer & {PRICE_W{chain[k].lo}});
			offer_hi = offer_hi | (chain[k].offer & {PRICE_W{chain[k].hi}});
		end
	end

	// floor mean without overflow; equal for an odd count
	logic [PRICE_W:0]   bid_sum;
	logic [PRICE_W:0]   offer_sum;
	logic [SW-1:0]      count_ext;
	logic [SIZE_W-1:0]  size_sat;

	assign bid_sum   = {1'b0, bid_lo} + {1'b0, bid_hi};
	assign offer_sum = {1'b0, offer_lo} + {1'b0, offer_hi};
	assign count_ext = SW'(count_q);
	assign size_sat  = (count_ext > SW'(63)) ? SIZE_W'(63) : count_ext[SIZE_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			date_q      <= '0;
			time_q      <= '0;
			sym_q       <= '0;
			mode_q      <= '0;
			dropped_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			if (do_emit) begin
				out_valid_q <= 1'b1;
			end
			if (do_flush) begin
				count_q   <= '0;
				dropped_q <= 1'b0;
			end
			if (do_start) begin
				count_q   <= CW'(1);
				date_q    <= in_date;
				time_q    <= in_time;
				sym_q     <= in_sym;
				mode_q    <= in_mode;
				dropped_q <= 1'b0;
			end
			if (do_insert) begin
				count_q <= count_q + CW'(1);
				sym_q   <= in_sym;
				mode_q  <= in_mode;
			end
			if (do_drop) begin
				dropped_q <= 1'b1;
			end
		end
	end

	// result beat payload
	always_ff @(posedge clk) begin
		if (do_emit) begin
			out_data_q <= {3'b000, dropped_q, size_sat, mode_q, bid_sum[PRICE_W:1],
				offer_sum[PRICE_W:1], time_q, date_q, sym_q};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule

### bench/tb_timestamp_group_median_merge.sv
`timescale 1ns / 1ps
// self-checking bench for timestamp_group_median_merge: quote beats in, merged quotes out
// depends on tgmm_pkg and the rtl top level; a built-in grouping predictor supplies expectations

module tb_timestamp_group_median_merge;
	import tgmm_pkg::*;

	localparam int MAX_GROUP  = 32;
	localparam int IDLE_LIMIT = 20000;

	// input beat as it sits in s_tdata, first field in the low bits
	typedef struct packed {
		logic [1:0]         pad;
		logic [MODE_W-1:0]  mode;
		logic [PRICE_W-1:0] offer;
		logic [PRICE_W-1:0] bid;
		logic [STAMP_W-1:0] qtime;
		logic [STAMP_W-1:0] qdate;
		logic [SYM_W-1:0]   sym;
	} quote_t;

	// merged quote as it sits in m_tdata
	typedef struct packed {
		logic [2:0]         pad;
		logic               ovf;
		logic [SIZE_W-1:0]  size;
		logic [MODE_W-1:0]  mode;
		logic [PRICE_W-1:0] bid;
		logic [PRICE_W-1:0] offer;
		logic [STAMP_W-1:0] qtime;
		logic [STAMP_W-1:0] qdate;
		logic [SYM_W-1:0]   sym;
	} merge_t;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata;
	logic                  s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;

	timestamp_group_median_merge #(.MAX_GROUP(MAX_GROUP)) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// predictor copy of the pending group
	logic [PRICE_W-1:0] bid_row [MAX_GROUP];
	logic [PRICE_W-1:0] offer_row [MAX_GROUP];
	int                 held_cnt;
	logic [STAMP_W-1:0] held_date;
	logic [STAMP_W-1:0] held_time;
	logic [SYM_W-1:0]   held_sym;
	logic [MODE_W-1:0]  held_mode;
	logic               held_drop;

	merge_t pending_merges[$];
	int     mismatches;
	int     quotes_sent;
	int     hold_left;
	bit     tx_quiet;
	bit     rx_quiet;
	logic [STAMP_W-1:0] cur_date;
	logic [STAMP_W-1:0] cur_time;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// mostly back to back, some short gaps, a few long ones
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 15);
		if (r < 9)
			return 0;
		if (r < 14)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [PRICE_W-1:0] middle_price(input logic [PRICE_W-1:0] row [MAX_GROUP],
			input int n);
		logic [PRICE_W:0] s;
		if (n % 2)
			return row[n / 2];
		s = {1'b0, row[n / 2 - 1]} + {1'b0, row[n / 2]};
		return s[PRICE_W:1];
	endfunction

	function automatic merge_t close_group();
		merge_t m;
		m       = '0;
		m.sym   = held_sym;
		m.qdate = held_date;
		m.qtime = held_time;
		m.offer = middle_price(offer_row, held_cnt);
		m.bid   = middle_price(bid_row, held_cnt);
		m.mode  = held_mode;
		m.size  = SIZE_W'((held_cnt > 63) ? 63 : held_cnt);
		m.ovf   = held_drop;
		return m;
	endfunction

	function automatic void open_group(input quote_t q);
		held_cnt     = 1;
		bid_row[0]   = q.bid;
		offer_row[0] = q.offer;
		held_date    = q.qdate;
		held_time    = q.qtime;
		held_sym     = q.sym;
		held_mode    = q.mode;
		held_drop    = 1'b0;
	endfunction

	// advance the group state by one accepted beat; returns 1 when a merged quote leaves
	function automatic bit fold_quote(input logic flush, input quote_t q, output merge_t m);
		int i;
		m = '0;
		if (flush) begin
			if (held_cnt == 0)
				return 0;
			m         = close_group();
			held_cnt  = 0;
			held_drop = 1'b0;
			return 1;
		end
		if (held_cnt == 0) begin
			open_group(q);
			return 0;
		end
		if (q.qdate == held_date && q.qtime == held_time) begin
			// full group: the quote is dropped whole, only the flag remembers it
			if (held_cnt >= MAX_GROUP) begin
				held_drop = 1'b1;
				return 0;
			end
			i = held_cnt;
			while (i > 0 && bid_row[i - 1] > q.bid) begin
				bid_row[i] = bid_row[i - 1];
				i--;
			end
			bid_row[i] = q.bid;
			i = held_cnt;
			while (i > 0 && offer_row[i - 1] > q.offer) begin
				offer_row[i] = offer_row[i - 1];
				i--;
			end
			offer_row[i] = q.offer;
			held_cnt++;
			held_sym  = q.sym;
			held_mode = q.mode;
			return 0;
		end
		m = close_group();
		open_group(q);
		return 1;
	endfunction

	// style 0: any value, 1: narrow band around base (many ties), 2: zero or full scale
	function automatic logic [PRICE_W-1:0] pick_price(input int style, input logic [PRICE_W-1:0] base);
		case (style)
			1: return base + $urandom_range(0, 3);
			2: return $urandom_range(0, 1) ? '1 : '0;
			default: return $urandom;
		endcase
	endfunction

	function automatic quote_t make_quote(input logic [STAMP_W-1:0] d, input logic [STAMP_W-1:0] t,
			input int style, input logic [PRICE_W-1:0] base);
		quote_t q;
		q       = '0;
		q.sym   = SYM_W'($urandom);
		q.mode  = MODE_W'($urandom);
		q.qdate = d;
		q.qtime = t;
		q.bid   = pick_price(style, base);
		q.offer = pick_price(style, base ^ 32'h0000_0002);
		return q;
	endfunction

	// pick a fresh timestamp, sometimes moving only the date or only the time
	function automatic void next_stamp();
		logic [STAMP_W-1:0] d0, t0;
		int r;
		d0 = cur_date;
		t0 = cur_time;
		r  = $urandom_range(0, 3);
		if (r != 1)
			cur_time = STAMP_W'($urandom);
		if (r != 0)
			cur_date = STAMP_W'($urandom);
		if (cur_date == d0 && cur_time == t0)
			cur_time[0] = ~cur_time[0];
	endfunction

	task automatic send_beat(input logic flush, input quote_t q);
		int     gap;
		merge_t m;
		gap = tx_quiet ? 0 : gap_len();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= flush;
		s_tdata  <= q;
		do begin
			@(posedge clk);
		end while (!s_tready);
		if (!flush)
			quotes_sent++;
		if (fold_quote(flush, q, m))
			pending_merges.insert(pending_merges.size(), m);
	endtask

	task automatic send_group(input int n);
		int style;
		logic [PRICE_W-1:0] base;
		style = $urandom_range(0, 2);
		base  = $urandom;
		next_stamp();
		repeat (n) send_beat(1'b0, make_quote(cur_date, cur_time, style, base));
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (pending_merges.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_directed();
		quote_t q;
		// flush with nothing pending, junk in the data
		send_beat(1'b1, make_quote(STAMP_W'($urandom), STAMP_W'($urandom), 0, 0));
		// lone quote at the field extremes passes through unchanged
		q = '0;
		q.sym = '1; q.mode = '1; q.qdate = '1; q.qtime = '0; q.bid = '0; q.offer = '1;
		send_beat(1'b0, q);
		send_beat(1'b1, make_quote(STAMP_W'($urandom), STAMP_W'($urandom), 0, 0));
		// pair of opposite extremes: floor mean must not wrap
		q.sym = '0; q.mode = '0; q.qdate = '0; q.qtime = '1; q.bid = '1; q.offer = '0;
		send_beat(1'b0, q);
		q.sym = 16'h1234; q.mode = 8'h5a; q.bid = '0; q.offer = '1;
		send_beat(1'b0, q);
		// same time, other date closes the pair
		q.qdate = 27'd19991231;
		send_beat(1'b0, q);
		// same date, other time closes the single
		q.qtime = 27'd34200000;
		q.bid = 32'd10; q.offer = 32'd3;
		send_beat(1'b0, q);
		q.sym = 16'h0001; q.bid = 32'd1; q.offer = 32'd3;
		send_beat(1'b0, q);
		q.sym = 16'h0002; q.bid = 32'd7; q.offer = 32'd9;
		send_beat(1'b0, q);
		q.sym = 16'h0003; q.mode = 8'h81; q.bid = 32'd4; q.offer = 32'd3;
		send_beat(1'b0, q);
		// flush closes the even group of four, second flush finds it empty
		send_beat(1'b1, make_quote(STAMP_W'($urandom), STAMP_W'($urandom), 0, 0));
		send_beat(1'b1, make_quote(STAMP_W'($urandom), STAMP_W'($urandom), 0, 0));
	endtask

	task automatic test_full_group();
		// two quotes past the cap are dropped and flagged
		send_group(MAX_GROUP + 2);
		// exactly at the cap, closed by a flush, no flag
		send_group(MAX_GROUP);
		send_beat(1'b1, make_quote(STAMP_W'($urandom), STAMP_W'($urandom), 0, 0));
		wait_drained();
	endtask

	task automatic test_random_groups(input int target);
		int stop_at;
		int r;
		stop_at = quotes_sent + target;
		while (quotes_sent < stop_at) begin
			// occasionally switch stretches of full-rate traffic on or off
			if ($urandom_range(0, 29) == 0) begin
				tx_quiet = ~tx_quiet;
				rx_quiet = tx_quiet;
			end
			r = $urandom_range(0, 19);
			if (r == 0)
				send_beat(1'b1, make_quote(STAMP_W'($urandom), STAMP_W'($urandom), 0, 0));
			else if (r < 14)
				send_group($urandom_range(1, 4));
			else if (r < 19)
				send_group($urandom_range(5, 12));
			else
				send_group($urandom_range(MAX_GROUP - 4, MAX_GROUP + 4));
		end
		tx_quiet = 0;
		rx_quiet = 0;
	endtask

	task automatic test_backpressure();
		// receiver holds off while single-quote groups keep coming at full rate
		hold_left = 300;
		tx_quiet  = 1;
		repeat (80) send_group(1);
		tx_quiet  = 0;
		send_beat(1'b1, make_quote(STAMP_W'($urandom), STAMP_W'($urandom), 0, 0));
	endtask

	task automatic test_drain_pause();
		repeat (6) send_group($urandom_range(1, 5));
		wait_drained();
		repeat (6) send_group($urandom_range(1, 5));
		send_beat(1'b1, make_quote(STAMP_W'($urandom), STAMP_W'($urandom), 0, 0));
	endtask

	// receiver: random stalls, a forced hold-off when asked
	always @(posedge clk) begin : rx_side
		int run_left;
		if (hold_left > 0) begin
			m_tready <= 1'b0;
			hold_left--;
			run_left = 0;
		end else if (run_left > 0) begin
			run_left--;
		end else if (rx_quiet || $urandom_range(0, 2) != 0) begin
			m_tready <= 1'b1;
			run_left = $urandom_range(1, 12);
		end else begin
			m_tready <= 1'b0;
			run_left = gap_len();
		end
	end

	task automatic note_mismatch(input string what, input merge_t e, input merge_t g);
		mismatches++;
		if (mismatches <= 10) begin
			$display("mismatch (%s) at %0t", what, $realtime);
			$display("  expected sym %h date %h time %h offer %h bid %h mode %h size %0d ovf %b",
				e.sym, e.qdate, e.qtime, e.offer, e.bid, e.mode, e.size, e.ovf);
			$display("  actual   sym %h date %h time %h offer %h bid %h mode %h size %0d ovf %b",
				g.sym, g.qdate, g.qtime, g.offer, g.bid, g.mode, g.size, g.ovf);
		end
	endtask

	// result checker
	always @(posedge clk) begin : merge_check
		merge_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata;
			if (pending_merges.size() == 0) begin
				note_mismatch("unexpected beat", '0, got);
			end else begin
				want = pending_merges.pop_front();
				if (got.sym !== want.sym || got.qdate !== want.qdate || got.qtime !== want.qtime
						|| got.offer !== want.offer || got.bid !== want.bid
						|| got.mode !== want.mode || got.size !== want.size
						|| got.ovf !== want.ovf)
					note_mismatch("field", want, got);
			end
		end
	end

	// watchdog on cycles without any beat moving
	always @(posedge clk) begin : idle_watch
		int idle_cycles;
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("timeout: no beat for %0d cycles", IDLE_LIMIT);
				$display("FAILED: results differ");
				$finish;
			end
		end
	end

	initial begin
		arst_n      = 1'b0;
		s_tvalid    = 1'b0;
		s_tdata     = '0;
		s_tuser     = 1'b0;
		m_tready    = 1'b0;
		held_cnt    = 0;
		held_date   = '0;
		held_time   = '0;
		held_sym    = '0;
		held_mode   = '0;
		held_drop   = 1'b0;
		mismatches  = 0;
		quotes_sent = 0;
		hold_left   = 0;
		tx_quiet    = 0;
		rx_quiet    = 0;
		cur_date    = '0;
		cur_time    = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_full_group();
		test_random_groups(640);
		test_backpressure();
		test_drain_pause();

		wait_drained();
		repeat (16) @(posedge clk);
		if (mismatches == 0 && pending_merges.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
